// ----- src/assert_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the JSON unescape block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication in the same cycle, disabled during reset.
`define ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Implication checked in the next cycle, disabled during reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- src/jsu_pkg.sv -----
// ----------------------------------------------------------------------------
// jsu_pkg
// Types, codes and helper functions of the JSON string unescaper.
// ----------------------------------------------------------------------------
package jsu_pkg;

    typedef enum logic [3:0] {
        PH_IDLE = 4'd0,
        PH_STR  = 4'd1,
        PH_ESC  = 4'd2,
        PH_HI   = 4'd3,
        PH_BS   = 4'd4,
        PH_U    = 4'd5,
        PH_LO   = 4'd6
    } t_phase;

    typedef enum logic [2:0] {
        ST_DATA    = 3'd0,
        ST_OK      = 3'd1,
        ST_SYNTAX  = 3'd2,
        ST_CTRL    = 3'd3,
        ST_UNKNOWN = 3'd4,
        ST_SHORT   = 3'd5,
        ST_NUL     = 3'd6,
        ST_LONE    = 3'd7
    } t_status;

    localparam logic [7:0]  CH_QUOTE   = 8'h22;
    localparam logic [7:0]  CH_BSLASH  = 8'h5C;
    localparam logic [7:0]  CH_U       = 8'h75;
    localparam logic [7:0]  CTRL_LIMIT = 8'h20;
    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_SUR_MIN = 16'hDC00;
    localparam logic [15:0] LO_SUR_MAX = 16'hDFFF;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;
    localparam int          MAX_RES    = 4;

    typedef struct packed {
        logic [7:0] data;
        t_status    st;
    } t_res;

    // Up to four results of one input byte, in delivery order.
    typedef struct packed {
        t_res [MAX_RES-1:0] res;
        logic [2:0]         cnt;
    } t_pkt;

    typedef struct packed {
        logic valid;
        t_pkt pkt;
    } t_push;

    typedef struct packed {
        logic valid;
        t_pkt pkt;
    } t_head;

    typedef struct packed {
        logic       ok;
        logic [3:0] value;
    } t_hex;

    function automatic t_hex hex_digit(input logic [7:0] c);
        t_hex h;
        h = '0;
        if (c >= 8'h30 && c <= 8'h39) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h30);
        end else if (c >= 8'h61 && c <= 8'h66) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h57);
        end else if (c >= 8'h41 && c <= 8'h46) begin
            h.ok    = 1'b1;
            h.value = 4'(c - 8'h37);
        end
        return h;
    endfunction

    // Returns zero for a byte that is not a simple escape letter.
    function automatic logic [7:0] simple_escape(input logic [7:0] e);
        logic [7:0] r;
        case (e)
            8'h22:   r = 8'h22;
            8'h5C:   r = 8'h5C;
            8'h2F:   r = 8'h2F;
            8'h62:   r = 8'h08;
            8'h66:   r = 8'h0C;
            8'h6E:   r = 8'h0A;
            8'h72:   r = 8'h0D;
            8'h74:   r = 8'h09;
            default: r = 8'h00;
        endcase
        return r;
    endfunction

    function automatic t_pkt one_result(input logic [7:0] data, input t_status st);
        t_pkt p;
        p              = '0;
        p.res[0].data  = data;
        p.res[0].st    = st;
        p.cnt          = 3'd1;
        return p;
    endfunction

    function automatic t_pkt utf8_encode(input logic [20:0] cp);
        t_pkt p;
        p = '0;
        if (cp < 21'h80) begin
            p.res[0].data = cp[7:0];
            p.cnt         = 3'd1;
        end else if (cp < 21'h800) begin
            p.res[0].data = {3'b110, cp[10:6]};
            p.res[1].data = {2'b10, cp[5:0]};
            p.cnt         = 3'd2;
        end else if (cp < SUPP_BASE) begin
            p.res[0].data = {4'b1110, cp[15:12]};
            p.res[1].data = {2'b10, cp[11:6]};
            p.res[2].data = {2'b10, cp[5:0]};
            p.cnt         = 3'd3;
        end else begin
            p.res[0].data = {5'b11110, cp[20:18]};
            p.res[1].data = {2'b10, cp[17:12]};
            p.res[2].data = {2'b10, cp[11:6]};
            p.res[3].data = {2'b10, cp[5:0]};
            p.cnt         = 3'd4;
        end
        return p;
    endfunction

endpackage

// ----- src/jsu_in_if.sv -----
// ----------------------------------------------------------------------------
// jsu_in_if
// Input channel: one text byte per transaction.
// ----------------------------------------------------------------------------
interface jsu_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       text_end;

    modport source (output valid, output in_byte, output text_end, input ready);
    modport sink   (input valid, input in_byte, input text_end, output ready);
endinterface

// ----- src/jsu_out_if.sv -----
// ----------------------------------------------------------------------------
// jsu_out_if
// Output channel: one decoded byte or status per transaction.
// ----------------------------------------------------------------------------
interface jsu_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic [2:0] status;
    logic       last;

    modport source (output valid, output out_byte, output status, output last,
                    input ready);
    modport sink   (input valid, input out_byte, input status, input last,
                    output ready);
endinterface

// ----- src/json_string_unescape_utf8.sv -----
// ----------------------------------------------------------------------------
// json_string_unescape_utf8
// Decodes a quoted JSON string, byte by byte, into UTF-8 bytes and a status.
// ----------------------------------------------------------------------------
// The block accepts one text byte per clock while the result queue has room,
// and turns each into zero to four result transactions: decoded UTF-8 bytes
// with status 0, and one final status (closed ok or an error) that ends every
// string. Results leave at one per cycle while the output is ready, so the
// output serializer sets the sustained rate when escapes expand. The results
// of a byte are registered into the queue when it is accepted and leave from
// the queue head. The queue depth sets how many result groups may wait while
// the output stalls.

module json_string_unescape_utf8
    import jsu_pkg::*;
#(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    jsu_in_if.sink    i_in,
    jsu_out_if.source o_out
);

    t_push push;
    t_head head;
    logic  full;
    logic  pop;

    jsu_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_full  (full),
        .o_push  (push)
    );

    jsu_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .o_full  (full),
        .o_head  (head),
        .i_pop   (pop)
    );

    jsu_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_head  (head),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ----- src/jsu_front.sv -----
// ----------------------------------------------------------------------------
// jsu_front
// Escape decoder: takes one byte a cycle while the queue has room and builds its group of results.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_front
    import jsu_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    jsu_in_if.sink   i_in,
    input  logic     i_full,
    output t_push    o_push
);

    t_phase      r_phase, n_phase;
    logic [15:0] r_hex_value, n_hex_value;
    logic [1:0]  r_hex_count, n_hex_count;
    logic [9:0]  r_high, n_high;

    logic        accept;
    logic [7:0]  c;
    logic        txt_end;
    t_hex        dig;
    logic [15:0] hv_full;
    logic [7:0]  esc;
    logic        fail_en;
    t_status     fail_st;
    t_pkt        pkt;

    assign i_in.ready = !i_full;
    assign accept     = i_in.valid && !i_full;
    assign c          = i_in.in_byte;
    assign txt_end    = i_in.text_end;
    assign dig        = hex_digit(c);
    assign hv_full    = {r_hex_value[11:0], dig.value};
    assign esc        = simple_escape(c);

    always_comb begin
        n_phase     = r_phase;
        n_hex_value = r_hex_value;
        n_hex_count = r_hex_count;
        n_high      = r_high;
        pkt         = '0;
        fail_en     = 1'b0;
        fail_st     = ST_SYNTAX;
        case (r_phase)
            PH_STR: begin
                if (c == CH_QUOTE) begin
                    pkt     = one_result(8'h00, ST_OK);
                    n_phase = PH_IDLE;
                end else if (c < CTRL_LIMIT) begin
                    fail_en = 1'b1;
                    fail_st = ST_CTRL;
                end else if (txt_end) begin
                    fail_en = 1'b1;
                end else if (c == CH_BSLASH) begin
                    n_phase = PH_ESC;
                end else begin
                    pkt = one_result(c, ST_DATA);
                end
            end
            PH_ESC: begin
                if (c == CH_U) begin
                    n_hex_value = '0;
                    n_hex_count = '0;
                    if (txt_end) begin
                        fail_en = 1'b1;
                        fail_st = ST_SHORT;
                    end else begin
                        n_phase = PH_HI;
                    end
                end else if (esc == 8'h00) begin
                    fail_en = 1'b1;
                    fail_st = ST_UNKNOWN;
                end else if (txt_end) begin
                    fail_en = 1'b1;
                end else begin
                    pkt     = one_result(esc, ST_DATA);
                    n_phase = PH_STR;
                end
            end
            PH_HI, PH_LO: begin
                if (!dig.ok) begin
                    fail_en = 1'b1;
                    fail_st = ST_SHORT;
                end else begin
                    n_hex_value = hv_full;
                    if (r_hex_count != 2'd3) begin
                        n_hex_count = r_hex_count + 2'd1;
                        if (txt_end) begin
                            fail_en = 1'b1;
                            fail_st = ST_SHORT;
                        end
                    end else begin
                        n_hex_count = '0;
                        if (r_phase == PH_HI) begin
                            if (hv_full == 16'h0000) begin
                                fail_en = 1'b1;
                                fail_st = ST_NUL;
                            end else if (hv_full >= LO_SUR_MIN && hv_full <= LO_SUR_MAX) begin
                                fail_en = 1'b1;
                                fail_st = ST_LONE;
                            end else if (hv_full >= HI_SUR_MIN && hv_full <= HI_SUR_MAX) begin
                                n_high = hv_full[9:0];
                                if (txt_end) begin
                                    fail_en = 1'b1;
                                    fail_st = ST_LONE;
                                end else begin
                                    n_phase = PH_BS;
                                end
                            end else if (txt_end) begin
                                fail_en = 1'b1;
                            end else begin
                                pkt     = utf8_encode({5'b0, hv_full});
                                n_phase = PH_STR;
                            end
                        end else begin
                            if (hv_full < LO_SUR_MIN || hv_full > LO_SUR_MAX) begin
                                fail_en = 1'b1;
                                fail_st = ST_LONE;
                            end else if (txt_end) begin
                                fail_en = 1'b1;
                            end else begin
                                // low half offset is simply its bottom ten bits
                                pkt = utf8_encode(SUPP_BASE
                                      + {1'b0, r_high, hv_full[9:0]});
                                n_phase = PH_STR;
                            end
                        end
                    end
                end
            end
            PH_BS: begin
                if (c != CH_BSLASH || txt_end) begin
                    fail_en = 1'b1;
                    fail_st = ST_LONE;
                end else begin
                    n_phase = PH_U;
                end
            end
            PH_U: begin
                if (c != CH_U) begin
                    fail_en = 1'b1;
                    fail_st = ST_LONE;
                end else begin
                    n_hex_value = '0;
                    n_hex_count = '0;
                    if (txt_end) begin
                        fail_en = 1'b1;
                        fail_st = ST_SHORT;
                    end else begin
                        n_phase = PH_LO;
                    end
                end
            end
            default: begin
                if (c != CH_QUOTE || txt_end) begin
                    fail_en = 1'b1;
                end else begin
                    n_phase = PH_STR;
                end
            end
        endcase
        // any error ends the string with one status
        if (fail_en) begin
            pkt     = one_result(8'h00, fail_st);
            n_phase = PH_IDLE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_IDLE;
            r_hex_value <= '0;
            r_hex_count <= '0;
            r_high      <= '0;
        end else if (accept) begin
            r_phase     <= n_phase;
            r_hex_value <= n_hex_value;
            r_hex_count <= n_hex_count;
            r_high      <= n_high;
        end
    end

    assign o_push.valid = accept && (pkt.cnt != 3'd0);
    assign o_push.pkt   = pkt;

    `ASSERT_NEXT(a_status_ends_string, i_clk, i_rst_n, o_push.valid && o_push.pkt.res[0].st != ST_DATA, r_phase == PH_IDLE)
    `ASSERT_IMPL(a_push_count_range, i_clk, i_rst_n, o_push.valid, o_push.pkt.cnt <= 3'(MAX_RES))

endmodule

// ----- src/jsu_queue.sv -----
// ----------------------------------------------------------------------------
// jsu_queue
// Short queue of result groups between the decoder and the serializer.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_queue
    import jsu_pkg::*;
#(
    parameter int DEPTH = 2
) (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  t_push i_push,
    output logic  o_full,
    output t_head o_head,
    input  logic  i_pop
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_pkt          r_slot [DEPTH];
    logic [AW-1:0] r_wr, n_wr;
    logic [AW-1:0] r_rd, n_rd;
    logic [CW-1:0] r_count, n_count;
    logic          do_pop;

    assign o_full       = (r_count == CW'(DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.pkt   = r_slot[r_rd];
    assign do_pop       = i_pop && o_head.valid;

    always_comb begin
        n_wr    = r_wr;
        n_rd    = r_rd;
        n_count = r_count;
        if (i_push.valid) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
        end
        if (i_push.valid && !do_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push.valid && do_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            r_wr    <= n_wr;
            r_rd    <= n_rd;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push.valid) begin
            r_slot[r_wr] <= i_push.pkt;
        end
    end

    `ASSERT_IMPL(a_no_push_when_full, i_clk, i_rst_n, i_push.valid, !o_full)

endmodule

// ----- src/jsu_back.sv -----
// ----------------------------------------------------------------------------
// jsu_back
// Serializer: delivers the results of the head group one per transaction.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_back
    import jsu_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_head     i_head,
    output logic      o_pop,
    jsu_out_if.source o_out
);

    logic [1:0] r_idx, n_idx;
    logic       is_last;
    logic       xfer;
    t_res       cur;

    assign cur     = i_head.pkt.res[r_idx];
    assign is_last = ({1'b0, r_idx} == (i_head.pkt.cnt - 3'd1));
    assign xfer    = i_head.valid && o_out.ready;

    assign o_out.valid    = i_head.valid;
    assign o_out.out_byte = cur.data;
    assign o_out.status   = cur.st;
    assign o_out.last     = is_last;
    assign o_pop          = xfer && is_last;

    always_comb begin
        n_idx = r_idx;
        if (xfer) begin
            // advance within the group, restart at the next one
            n_idx = is_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else begin
            r_idx <= n_idx;
        end
    end

    `ASSERT_IMPL(a_index_in_group, i_clk, i_rst_n, i_head.valid, {1'b0, r_idx} < i_head.pkt.cnt)

endmodule
